// ===== rtl/core/xbus_channel_receiver_show_control_top_defines.svh =====
// Assertion macros shared by the checker of the channel receiver top level
`ifndef XBUS_CHANNEL_RECEIVER_SHOW_CONTROL_TOP_DEFINES_SVH
`define XBUS_CHANNEL_RECEIVER_SHOW_CONTROL_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define XBCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define XBCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/xbcr_pkg.sv =====
// Shared constants, types and helpers of the channel receiver
package xbcr_pkg;

    localparam int MAX_CHANNEL = 22;
    localparam int CH_W        = 5;
    localparam int US_W        = 12;
    localparam int CNT_W       = 4;
    localparam int IN_W        = 8;
    localparam int OUT_W       = 24;
    localparam int POS_W       = 16;
    localparam int PROD_W      = 27;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [10:0]       US_SCALE = 11'd1400;
    localparam logic [PROD_W-1:0] US_ROUND = 27'd32767;
    localparam logic [US_W-1:0]   US_BASE  = 12'd800;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 4'd15;

    localparam logic [US_W-1:0]  RST_START_TH = 12'd1900;
    localparam logic [US_W-1:0]  RST_STOP_TH  = 12'd1200;
    localparam logic [US_W-1:0]  RST_BAIL_TH  = 12'd1800;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE = 4'd5;
    localparam logic [CH_W-1:0]  RST_START_CH = 5'd6;
    localparam logic [CH_W-1:0]  RST_BAIL_CH  = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_TH = 3'd0,
        REG_STOP_TH  = 3'd1,
        REG_BAIL_TH  = 3'd2,
        REG_DEBOUNCE = 3'd3,
        REG_START_CH = 3'd4,
        REG_BAIL_CH  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_NONE        = 2'd0,
        EV_START       = 2'd1,
        EV_SWITCH_STOP = 2'd2,
        EV_BAIL_STOP   = 2'd3
    } show_event_t;

    typedef struct packed {
        logic [US_W-1:0]  start_th;
        logic [US_W-1:0]  stop_th;
        logic [US_W-1:0]  bail_th;
        logic [CNT_W-1:0] debounce;
        logic [CH_W-1:0]  start_ch;
        logic [CH_W-1:0]  bail_ch;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   ch;
        logic [PROD_W-1:0] prod;
    } rec_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        logic [US_W-1:0] data;
    } chan_wr_t;

    function automatic logic ch_in_range(input logic [CH_W-1:0] ch);
        return (ch != '0) && (ch <= CH_W'(MAX_CHANNEL));
    endfunction

endpackage

// ===== rtl/core/xbcr_window.sv =====
// Byte window with record header search and scaled position register
module xbcr_window (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       byte_accept,
    input  logic [xbcr_pkg::IN_W-1:0]  byte_data,
    input  logic                       rec_take,
    output logic                       rec_issue,
    output xbcr_pkg::rec_t             rec
);
    import xbcr_pkg::*;

    logic [IN_W-1:0]   win_reg [3];
    logic [1:0]        fill_reg, fill_next;
    logic              header_ok;
    logic [POS_W-1:0]  pos;
    logic              rec_valid_reg;
    logic [CH_W-1:0]   rec_ch_reg;
    logic [PROD_W-1:0] rec_prod_reg;

    assign header_ok = (win_reg[0] != '0) && (win_reg[0] <= IN_W'(MAX_CHANNEL)) &&
                       (win_reg[1] == '0);
    assign pos       = {win_reg[2], byte_data};
    assign rec_issue = byte_accept && (fill_reg == 2'd3) && header_ok;

    always_comb begin
        fill_next = fill_reg;
        if (byte_accept) begin
            if (fill_reg != 2'd3) begin
                fill_next = fill_reg + 2'd1;
            end else if (header_ok) begin
                fill_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= 2'd0;
            rec_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (rec_issue) begin
                rec_valid_reg <= 1'b1;
            end else if (rec_take) begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            if (fill_reg != 2'd3) begin
                win_reg[fill_reg] <= byte_data;
            end else if (!header_ok) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= byte_data;
            end
        end
        if (rec_issue) begin
            rec_ch_reg   <= win_reg[0][CH_W-1:0];
            rec_prod_reg <= PROD_W'(pos) * PROD_W'(US_SCALE) + US_ROUND;
        end
    end

    assign rec.valid = rec_valid_reg;
    assign rec.ch    = rec_ch_reg;
    assign rec.prod  = rec_prod_reg;

endmodule

// ===== rtl/core/xbcr_chan_mem.sv =====
// Per-channel value memory with two registered read ports, write forwarding and valid bits
module xbcr_chan_mem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [xbcr_pkg::CH_W-1:0]  rd_addr_a,
    input  logic [xbcr_pkg::CH_W-1:0]  rd_addr_b,
    input  xbcr_pkg::chan_wr_t         wr,
    output logic [xbcr_pkg::US_W-1:0]  rd_data_a,
    output logic [xbcr_pkg::US_W-1:0]  rd_data_b
);
    import xbcr_pkg::*;

    logic [US_W-1:0]    mem [MAX_CHANNEL+1];
    logic [MAX_CHANNEL:0] vld_reg;
    logic [US_W-1:0]    q_a_reg, q_b_reg;
    logic               ok_a_reg, ok_b_reg;
    logic               hit_a, hit_b;

    // pass a write on the same edge through to the read
    assign hit_a = wr.en && (wr.addr == rd_addr_a);
    assign hit_b = wr.en && (wr.addr == rd_addr_b);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            q_a_reg <= hit_a ? wr.data : mem[rd_addr_a];
            q_b_reg <= hit_b ? wr.data : mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            ok_a_reg <= 1'b0;
            ok_b_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                ok_a_reg <= ch_in_range(rd_addr_a) ? (vld_reg[rd_addr_a] || hit_a) : 1'b0;
                ok_b_reg <= ch_in_range(rd_addr_b) ? (vld_reg[rd_addr_b] || hit_b) : 1'b0;
            end
        end
    end

    assign rd_data_a = ok_a_reg ? q_a_reg : '0;
    assign rd_data_b = ok_b_reg ? q_b_reg : '0;

endmodule

// ===== rtl/core/xbcr_show_ctrl.sv =====
// Position conversion, show start/stop debounce and result register
module xbcr_show_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  xbcr_pkg::cfg_t              cfg,
    input  xbcr_pkg::rec_t              rec,
    input  logic [xbcr_pkg::US_W-1:0]   start_mem,
    input  logic [xbcr_pkg::US_W-1:0]   bail_mem,
    input  logic                        m_tready,
    output logic                        rec_take,
    output xbcr_pkg::chan_wr_t          wr,
    output logic                        m_tvalid,
    output logic [xbcr_pkg::OUT_W-1:0]  m_tdata
);
    import xbcr_pkg::*;

    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [US_W-1:0]   out_us_reg;
    logic              out_active_reg;
    show_event_t       out_event_reg;
    logic              running_reg, running_next;
    logic [CNT_W-1:0]  high_cnt_reg, high_cnt_next;
    logic [CNT_W-1:0]  low_cnt_reg, low_cnt_next;
    show_event_t       event_next;
    logic              adv;
    logic [PROD_W:0]   quot_sum;
    logic [US_W-1:0]   us;
    logic [US_W-1:0]   start_val, bail_val;

    assign adv      = !out_valid_reg || m_tready;
    assign rec_take = rec.valid && adv;

    // divide by 65535: (x + (x >> 16) + 1) >> 16
    assign quot_sum = (PROD_W+1)'(rec.prod) + (PROD_W+1)'(rec.prod >> 16) + 1'b1;
    assign us       = US_BASE + US_W'(quot_sum[PROD_W:16]);

    // forward this record's own value past the memory read
    assign start_val = (rec.ch == cfg.start_ch) ? us : start_mem;
    assign bail_val  = (rec.ch == cfg.bail_ch)  ? us : bail_mem;

    assign wr.en   = rec_take;
    assign wr.addr = rec.ch;
    assign wr.data = us;

    always_comb begin
        running_next  = running_reg;
        high_cnt_next = high_cnt_reg;
        low_cnt_next  = low_cnt_reg;
        event_next    = EV_NONE;
        if ((bail_val > cfg.bail_th) && running_next) begin
            running_next  = 1'b0;
            event_next    = EV_BAIL_STOP;
            high_cnt_next = '0;
            low_cnt_next  = '0;
        end
        if (start_val > cfg.start_th) begin
            high_cnt_next = (high_cnt_next < CNT_MAX) ? high_cnt_next + 1'b1 : CNT_MAX;
            if ((high_cnt_next >= cfg.debounce) && !running_next) begin
                running_next = 1'b1;
                event_next   = EV_START;
            end
            low_cnt_next = '0;
        end else if (start_val < cfg.stop_th) begin
            low_cnt_next = (low_cnt_next < CNT_MAX) ? low_cnt_next + 1'b1 : CNT_MAX;
            if ((low_cnt_next >= cfg.debounce) && running_next) begin
                running_next = 1'b0;
                event_next   = EV_SWITCH_STOP;
            end
            high_cnt_next = '0;
        end else begin
            high_cnt_next = '0;
            low_cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            high_cnt_reg  <= '0;
            low_cnt_reg   <= '0;
        end else begin
            if (rec_take) begin
                out_valid_reg <= 1'b1;
                running_reg   <= running_next;
                high_cnt_reg  <= high_cnt_next;
                low_cnt_reg   <= low_cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_take) begin
            out_ch_reg     <= rec.ch;
            out_us_reg     <= us;
            out_active_reg <= running_next;
            out_event_reg  <= event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_event_reg, out_active_reg, out_us_reg, out_ch_reg};

endmodule

// ===== rtl/core/xbus_channel_receiver_show_control_top.sv =====
// Path: a record's last byte loads the record register, then the result register.
// Throughput: one byte per cycle; input stalls only while a record waits behind an
//   unaccepted result beat. Records are at least four bytes apart.
// Reset: synchronous on aresetn low; clears the byte window, the channel valid bits,
//   the debounce counters and show state, and restores register defaults.
module xbus_channel_receiver_show_control_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [xbcr_pkg::IN_W-1:0]        s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [xbcr_pkg::OUT_W-1:0]       m_tdata,   // [4:0] channel_id,
                                                        // [16:5] pulse_width_us,
                                                        // [17] show_active,
                                                        // [19:18] show_event
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [xbcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xbcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import xbcr_pkg::*;

    cfg_t        cfg_reg;
    rec_t        rec;
    chan_wr_t    wr;
    logic        rec_issue;
    logic        rec_take;
    logic        byte_accept;
    logic [US_W-1:0] start_mem, bail_mem;

    assign cfg_ready   = aresetn;
    assign s_tready    = aresetn && (!rec.valid || rec_take);
    assign byte_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_th <= RST_START_TH;
            cfg_reg.stop_th  <= RST_STOP_TH;
            cfg_reg.bail_th  <= RST_BAIL_TH;
            cfg_reg.debounce <= RST_DEBOUNCE;
            cfg_reg.start_ch <= RST_START_CH;
            cfg_reg.bail_ch  <= RST_BAIL_CH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_START_TH: cfg_reg.start_th <= cfg_data[US_W-1:0];
                REG_STOP_TH:  cfg_reg.stop_th  <= cfg_data[US_W-1:0];
                REG_BAIL_TH:  cfg_reg.bail_th  <= cfg_data[US_W-1:0];
                REG_DEBOUNCE: cfg_reg.debounce <= cfg_data[CNT_W-1:0];
                REG_START_CH: cfg_reg.start_ch <= cfg_data[CH_W-1:0];
                REG_BAIL_CH:  cfg_reg.bail_ch  <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    xbcr_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .byte_data   (s_tdata),
        .rec_take    (rec_take),
        .rec_issue   (rec_issue),
        .rec         (rec)
    );

    xbcr_chan_mem u_chan_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (rec_issue),
        .rd_addr_a (cfg_reg.start_ch),
        .rd_addr_b (cfg_reg.bail_ch),
        .wr        (wr),
        .rd_data_a (start_mem),
        .rd_data_b (bail_mem)
    );

    xbcr_show_ctrl u_show_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec       (rec),
        .start_mem (start_mem),
        .bail_mem  (bail_mem),
        .m_tready  (m_tready),
        .rec_take  (rec_take),
        .wr        (wr),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/core/xbcr_checker.sv =====
// Port-level checker of the channel receiver top level, with its bind
`include "xbus_channel_receiver_show_control_top_defines.svh"

module xbcr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [xbcr_pkg::OUT_W-1:0]  m_tdata
);
    import xbcr_pkg::*;

    logic in_acc;
    logic in_acc_d1_reg;
    logic in_acc_d2_reg;

    assign in_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_acc_d1_reg <= 1'b0;
            in_acc_d2_reg <= 1'b0;
        end else begin
            in_acc_d1_reg <= in_acc;
            in_acc_d2_reg <= in_acc_d1_reg;
        end
    end

    `XBCR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result beat changed while stalled")
    `XBCR_ASSERT_SAME(a_start_active, m_tvalid && (m_tdata[19:18] == EV_START), m_tdata[17],
        "start event without active show")
    `XBCR_ASSERT_SAME(a_stop_idle,
        m_tvalid && ((m_tdata[19:18] == EV_SWITCH_STOP) || (m_tdata[19:18] == EV_BAIL_STOP)),
        !m_tdata[17], "stop event with active show")
    `XBCR_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready,
        "input stalled without a blocked result beat")
    `XBCR_ASSERT_SAME(a_fresh_result, $rose(m_tvalid), in_acc_d2_reg,
        "result beat without a byte two cycles earlier")

endmodule

bind xbus_channel_receiver_show_control_top xbcr_checker u_xbcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
